// ----- hdl/lmsd_pkg.sv -----
// Shared types, constants and lookup functions for the LED matrix scan driver.
package lmsd_pkg;

    localparam int FRAME_BYTES = 512;
    localparam int ROW_BYTES   = 8;
    localparam int PANEL_ROWS  = 64;

    localparam int HALF_BYTES = FRAME_BYTES / 2;
    localparam int ROW_PAIRS  = PANEL_ROWS / 2;
    localparam int FB_AW      = $clog2(FRAME_BYTES);
    localparam int BC_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int RP_W       = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
    localparam int IDX_W      = 16;
    localparam int ADDR_W     = 5;
    localparam int PIN_W      = 14;
    localparam int CNT_W      = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESSING  = 2'd2;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] AM_BINARY = 2'd0;
    localparam logic [1:0] AM_AC     = 2'd1;

    typedef enum logic [1:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_EXEC
    } t_ctrl_state;

    typedef enum logic [2:0] {
        PH_CLK_HIGH,
        PH_CLK_LOW,
        PH_ADDR,
        PH_AC_LOW,
        PH_LATCH,
        PH_ON
    } t_scan_phase;

    typedef struct packed {
        logic clr_en;
        logic wr_en;
        logic tick_en;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_stall;
    } t_dp_status;

    // Drive channels enabled by a color mode: bit 0 red, bit 1 green, bit 2 blue.
    function automatic logic [2:0] chan_mask(input logic [2:0] mode);
        logic [2:0] m;
        unique case (mode)
            3'd0:    m = 3'b001;
            3'd1:    m = 3'b010;
            3'd2:    m = 3'b100;
            3'd3:    m = 3'b011;
            3'd4:    m = 3'b101;
            3'd5:    m = 3'b110;
            3'd6:    m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    // On time in ticks for a brightness level.
    function automatic logic [CNT_W-1:0] on_ticks(input logic [2:0] level);
        logic [CNT_W-1:0] t;
        unique case (level)
            3'd0:    t = 8'd1;
            3'd1:    t = 8'd10;
            3'd2:    t = 8'd50;
            3'd3:    t = 8'd150;
            3'd4:    t = 8'd250;
            default: t = 8'd50;
        endcase
        return t;
    endfunction

endpackage

// ----- hdl/lmsd_ctrl.sv -----
// Controller state machine: clearing pass, transaction acceptance and tick sequencing.
module lmsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_req_type,
    input  lmsd_pkg::t_dp_status  i_status,
    output logic                  o_s_tready,
    output lmsd_pkg::t_dp_cmd     o_cmd
);

    lmsd_pkg::t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmsd_pkg::CS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmsd_pkg::CS_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = lmsd_pkg::CS_IDLE;
                end
            end
            lmsd_pkg::CS_IDLE: begin
                if (i_s_tvalid && (i_req_type == lmsd_pkg::REQ_TICK)) begin
                    n_state = lmsd_pkg::CS_EXEC;
                end
            end
            lmsd_pkg::CS_EXEC: begin
                if (!i_status.out_stall) begin
                    n_state = lmsd_pkg::CS_IDLE;
                end
            end
            default: n_state = lmsd_pkg::CS_CLEAR;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.clr_en  = 1'b0;
        o_cmd.wr_en   = 1'b0;
        o_cmd.tick_en = 1'b0;
        unique case (r_state)
            lmsd_pkg::CS_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            lmsd_pkg::CS_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.wr_en = i_s_tvalid && (i_req_type == lmsd_pkg::REQ_WRITE);
            end
            lmsd_pkg::CS_EXEC: begin
                o_cmd.tick_en = !i_status.out_stall;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/lmsd_datapath.sv -----
// Datapath: framebuffer memory, configuration registers, scan counters and pin registers.
module lmsd_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lmsd_pkg::t_dp_cmd                     i_cmd,
    output lmsd_pkg::t_dp_status                  o_status,
    input  logic [8:0]                            i_write_addr,
    input  logic [7:0]                            i_write_data,
    input  logic                                  i_cfg_we,
    input  logic [lmsd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lmsd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [lmsd_pkg::PIN_W-1:0]            o_pins
);

    // Framebuffer with one write port and two registered read ports.
    logic [7:0]                    r_mem [lmsd_pkg::FRAME_BYTES];
    logic [lmsd_pkg::FB_AW-1:0]    r_clr_addr;
    logic [7:0]                    r_rd_up, r_rd_lo;
    logic                          r_up_ok, r_lo_ok;

    logic [2:0]                    r_color_mode;
    logic [2:0]                    r_brightness;
    logic [1:0]                    r_addr_mode;

    logic [lmsd_pkg::RP_W-1:0]     r_row_pair, n_row_pair;
    logic [lmsd_pkg::BC_W-1:0]     r_byte_col, n_byte_col;
    logic [2:0]                    r_bit_idx, n_bit_idx;
    lmsd_pkg::t_scan_phase         r_phase, n_phase;
    logic [lmsd_pkg::CNT_W-1:0]    r_on_cnt, n_on_cnt;

    logic [5:0]                    r_data_pins, n_data_pins;
    logic                          r_clk_pin, n_clk_pin;
    logic                          r_lat_pin, n_lat_pin;
    logic                          r_oe_pin, n_oe_pin;
    logic [lmsd_pkg::ADDR_W-1:0]   r_addr_pins, n_addr_pins;

    logic [lmsd_pkg::PIN_W-1:0]    r_out_pins;
    logic                          r_out_valid;

    logic [lmsd_pkg::IDX_W-1:0]    up_idx, lo_idx;
    logic                          mem_we;
    logic [lmsd_pkg::FB_AW-1:0]    mem_waddr;
    logic [7:0]                    mem_wdata;
    logic                          up_bit, lo_bit;
    logic [2:0]                    mask;
    logic [lmsd_pkg::CNT_W-1:0]    cnt_dec;

    assign up_idx = lmsd_pkg::IDX_W'(r_row_pair) * lmsd_pkg::IDX_W'(lmsd_pkg::ROW_BYTES)
                  + lmsd_pkg::IDX_W'(r_byte_col);
    assign lo_idx = up_idx + lmsd_pkg::IDX_W'(lmsd_pkg::HALF_BYTES);

    always_comb begin
        if (i_cmd.clr_en) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'd0;
        end else begin
            mem_we    = i_cmd.wr_en && (32'(i_write_addr) < lmsd_pkg::FRAME_BYTES);
            mem_waddr = lmsd_pkg::FB_AW'(i_write_addr);
            mem_wdata = i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_up <= r_mem[up_idx[lmsd_pkg::FB_AW-1:0]];
        r_rd_lo <= r_mem[lo_idx[lmsd_pkg::FB_AW-1:0]];
        r_up_ok <= (32'(up_idx) < lmsd_pkg::FRAME_BYTES);
        r_lo_ok <= (32'(lo_idx) < lmsd_pkg::FRAME_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == lmsd_pkg::FB_AW'(lmsd_pkg::FRAME_BYTES - 1));
    assign o_status.out_stall = r_out_valid && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 3'd0;
            r_brightness <= 3'd5;
            r_addr_mode  <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lmsd_pkg::CFG_COLOR_MODE: r_color_mode <= i_cfg_wdata;
                lmsd_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
                lmsd_pkg::CFG_ADDRESSING: r_addr_mode  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign mask    = lmsd_pkg::chan_mask(r_color_mode);
    assign up_bit  = r_up_ok && r_rd_up[r_bit_idx];
    assign lo_bit  = r_lo_ok && r_rd_lo[r_bit_idx];
    assign cnt_dec = (r_on_cnt != '0) ? (r_on_cnt - 1'b1) : r_on_cnt;

    always_comb begin
        n_row_pair  = r_row_pair;
        n_byte_col  = r_byte_col;
        n_bit_idx   = r_bit_idx;
        n_phase     = r_phase;
        n_on_cnt    = r_on_cnt;
        n_data_pins = r_data_pins;
        n_clk_pin   = r_clk_pin;
        n_lat_pin   = r_lat_pin;
        n_oe_pin    = r_oe_pin;
        n_addr_pins = r_addr_pins;
        if (i_cmd.tick_en) begin
            unique case (r_phase)
                lmsd_pkg::PH_CLK_HIGH: begin
                    n_data_pins = {{3{lo_bit}} & mask, {3{up_bit}} & mask};
                    n_clk_pin   = 1'b1;
                    n_lat_pin   = 1'b0;
                    n_oe_pin    = 1'b1;
                    n_phase     = lmsd_pkg::PH_CLK_LOW;
                end
                lmsd_pkg::PH_CLK_LOW: begin
                    n_clk_pin = 1'b0;
                    if (r_bit_idx != 3'd0) begin
                        n_bit_idx = r_bit_idx - 1'b1;
                        n_phase   = lmsd_pkg::PH_CLK_HIGH;
                    end else begin
                        n_bit_idx = 3'd7;
                        if (r_byte_col == lmsd_pkg::BC_W'(lmsd_pkg::ROW_BYTES - 1)) begin
                            n_byte_col = '0;
                            if (r_addr_mode == lmsd_pkg::AM_BINARY
                                    || r_addr_mode == lmsd_pkg::AM_AC) begin
                                n_phase = lmsd_pkg::PH_ADDR;
                            end else begin
                                n_phase = lmsd_pkg::PH_LATCH;
                            end
                        end else begin
                            n_byte_col = r_byte_col + 1'b1;
                            n_phase    = lmsd_pkg::PH_CLK_HIGH;
                        end
                    end
                end
                lmsd_pkg::PH_ADDR: begin
                    if (r_addr_mode == lmsd_pkg::AM_BINARY) begin
                        n_addr_pins = lmsd_pkg::ADDR_W'(r_row_pair);
                        n_phase     = lmsd_pkg::PH_LATCH;
                    end else if (r_addr_mode == lmsd_pkg::AM_AC) begin
                        // AC panels: pulse line A, line C marks the first row pair.
                        n_addr_pins[2] = (r_row_pair == '0);
                        n_addr_pins[0] = 1'b1;
                        n_phase        = lmsd_pkg::PH_AC_LOW;
                    end else begin
                        n_phase = lmsd_pkg::PH_LATCH;
                    end
                end
                lmsd_pkg::PH_AC_LOW: begin
                    n_addr_pins[0] = 1'b0;
                    n_phase        = lmsd_pkg::PH_LATCH;
                end
                lmsd_pkg::PH_LATCH: begin
                    n_lat_pin = 1'b1;
                    n_on_cnt  = lmsd_pkg::on_ticks(r_brightness);
                    n_phase   = lmsd_pkg::PH_ON;
                end
                default: begin
                    n_lat_pin = 1'b0;
                    n_oe_pin  = 1'b0;
                    n_on_cnt  = cnt_dec;
                    if (cnt_dec == '0) begin
                        if (r_row_pair == lmsd_pkg::RP_W'(lmsd_pkg::ROW_PAIRS - 1)) begin
                            n_row_pair = '0;
                        end else begin
                            n_row_pair = r_row_pair + 1'b1;
                        end
                        n_byte_col = '0;
                        n_bit_idx  = 3'd7;
                        n_phase    = lmsd_pkg::PH_CLK_HIGH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pair  <= '0;
            r_byte_col  <= '0;
            r_bit_idx   <= 3'd7;
            r_phase     <= lmsd_pkg::PH_CLK_HIGH;
            r_on_cnt    <= '0;
            r_data_pins <= '0;
            r_clk_pin   <= 1'b0;
            r_lat_pin   <= 1'b0;
            r_oe_pin    <= 1'b1;
            r_addr_pins <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row_pair  <= n_row_pair;
            r_byte_col  <= n_byte_col;
            r_bit_idx   <= n_bit_idx;
            r_phase     <= n_phase;
            r_on_cnt    <= n_on_cnt;
            r_data_pins <= n_data_pins;
            r_clk_pin   <= n_clk_pin;
            r_lat_pin   <= n_lat_pin;
            r_oe_pin    <= n_oe_pin;
            r_addr_pins <= n_addr_pins;
            if (i_cmd.tick_en) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_en) begin
            r_out_pins <= {n_addr_pins, n_oe_pin, n_lat_pin, n_clk_pin, n_data_pins};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_pins     = r_out_pins;

endmodule

// ----- hdl/led_matrix_scan_driver.sv -----
// Top level of the HUB75 LED matrix scan driver, with a bit per pixel in the framebuffer.
// A framebuffer write is stored at the edge that accepts it; a scan tick is carried out in
// the execute state after its acceptance, held there while the output stalls. The two
// framebuffer read ports are registered. Sustained rate: one write per cycle; a tick blocks
// the input until its step is taken. Reset is synchronous and active low; after it a
// clearing pass zeroes the FRAME_BYTES (512) bytes one per cycle, taking no transaction.
module led_matrix_scan_driver (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata from bit 0: write_addr[8:0], write_data[16:9], zero fill[23:17].
    input  logic [lmsd_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    // tuser from bit 0: req_type (0 scan tick, 1 framebuffer write).
    input  logic [0:0]                             i_s_tuser,
    // Output stream.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata from bit 0: red_upper, green_upper, blue_upper, red_lower, green_lower,
    // blue_lower, shift_clock, latch_line, output_enable, row_address[13:9], zeros.
    output logic [lmsd_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [lmsd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lmsd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    lmsd_pkg::t_dp_cmd              w_cmd;
    lmsd_pkg::t_dp_status           w_status;
    logic [lmsd_pkg::PIN_W-1:0]     w_pins;

    // The controller owns the handshake on the input side: it holds off
    // transactions during the clearing pass and while a tick is in flight.
    lmsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_type (i_s_tuser[0]),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the framebuffer, the scan sequencer registers and
    // the result register that parts the output side from the input side.
    lmsd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_write_addr (i_s_tdata[8:0]),
        .i_write_data (i_s_tdata[16:9]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_pins       (w_pins)
    );

    assign o_m_tdata = {(lmsd_pkg::OUT_TDATA_W - lmsd_pkg::PIN_W)'(0), w_pins};

    // A tick step always leaves a result waiting in the output register.
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tick_en |=> o_m_tvalid)
        else $error("tick step did not produce a result");

    // An accepted tick blocks the input side for the following cycle.
    a_tick_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == lmsd_pkg::REQ_TICK)) |=> !o_s_tready)
        else $error("input accepted while a tick was in flight");

    // Framebuffer writes from the stream only happen on an accepted transaction.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> (o_s_tready && i_s_tvalid && !w_cmd.clr_en))
        else $error("framebuffer write outside an accepted transaction");

    // A tick step never overwrites a result that is still stalled at the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tick_en |-> !(o_m_tvalid && !i_m_tready))
        else $error("result overwritten while stalled");

endmodule
